### design/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants for the prefix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int SYM_W   = 8;
   localparam int VALUE_W = 32;

   localparam logic [SYM_W-1:0] SYM_ADD  = 8'd43;
   localparam logic [SYM_W-1:0] SYM_MUL  = 8'd42;
   localparam logic [SYM_W-1:0] SYM_ZERO = 8'd48;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_CALC,
      S_DRAIN,
      S_POP_OP,
      S_FINAL
   } state_type;

   // commands from controller to datapath, at most one per cycle
   typedef struct packed {
      logic load;
      logic push_op;
      logic push_operand;
      logic start_combine;
      logic pop_a;
      logic pop_pair;
      logic calc;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic is_operator;
      logic is_last;
      logic prev_operand;
      logic ops_empty;
      logic rsp_hold;
   } dp_status_type;

endpackage

### design/pee_channels.sv
// ----------------------------------------------------------------------------
// pee_channels
// Valid/ready channel interfaces for the request and response sides.
// ----------------------------------------------------------------------------
interface pee_req_if import pee_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             last;

   modport source (output valid, symbol, last, input ready);
   modport sink   (input valid, symbol, last, output ready);
endinterface

interface pee_rsp_if import pee_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      error;

   modport source (output valid, value, error, input ready);
   modport sink   (input valid, value, error, output ready);
endinterface

### design/pee_datapath.sv
// ----------------------------------------------------------------------------
// pee_datapath
// Value and operator stacks, combine unit and response register.
// ----------------------------------------------------------------------------
module pee_datapath import pee_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic               req_last,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_error,
   output logic               rsp_valid,
   input  logic               rsp_ready
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

   logic [VALUE_W-1:0] vmem [STACK_DEPTH];
   logic               omem [STACK_DEPTH];

   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   vcount_ff, vcount_in;
   logic [CNT_W-1:0]   ocount_ff, ocount_in;
   logic               prev_ff, prev_in;
   logic               err_ff, err_in;
   logic [VALUE_W-1:0] a_ff, a_in;
   logic               vzero_ff, vzero_in;
   logic [VALUE_W-1:0] vrd_ff;
   logic               ord_ff;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_error_ff, rsp_error_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [VALUE_W-1:0] operand, popped, result, push_data;
   logic [CNT_W-1:0]   vtop, otop;
   logic               val_pop, op_pop, val_push_req;
   logic               vempty, vfull, ofull;
   logic               vwr_en, owr_en, vrd_en;

   always_comb begin
      operand      = {{(VALUE_W-SYM_W){1'b0}}, sym_ff} - {{(VALUE_W-SYM_W){1'b0}}, SYM_ZERO};
      popped       = vzero_ff ? '0 : vrd_ff;
      result       = ord_ff ? (a_ff * popped) : (a_ff + popped);
      val_pop      = cmd.start_combine | cmd.pop_pair | cmd.pop_a;
      op_pop       = cmd.start_combine | cmd.pop_pair;
      val_push_req = cmd.push_operand | cmd.calc;
      push_data    = cmd.calc ? result : operand;
      vempty       = (vcount_ff == '0);
      vfull        = (vcount_ff == FULL_CNT);
      ofull        = (ocount_ff == FULL_CNT);
      vwr_en       = val_push_req & ~vfull;
      owr_en       = cmd.push_op & ~ofull;
      vrd_en       = val_pop & ~vempty;
      vtop         = vcount_ff - CNT_W'(1);
      otop         = ocount_ff - CNT_W'(1);
   end

   always_comb begin
      sym_in       = cmd.load ? req_symbol : sym_ff;
      last_in      = cmd.load ? req_last : last_ff;
      vcount_in    = vcount_ff;
      ocount_in    = ocount_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      a_in         = a_ff;
      vzero_in     = val_pop ? vempty : vzero_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (cmd.finish) begin
         vcount_in    = '0;
         ocount_in    = '0;
         prev_in      = 1'b0;
         err_in       = 1'b0;
         rsp_value_in = popped;
         rsp_error_in = err_ff;
         rsp_valid_in = 1'b1;
      end else begin
         if (vwr_en) begin
            vcount_in = vcount_ff + CNT_W'(1);
         end else if (vrd_en) begin
            vcount_in = vtop;
         end
         if (owr_en) begin
            ocount_in = ocount_ff + CNT_W'(1);
         end else if (op_pop) begin
            ocount_in = otop;
         end
         // overflow, underflow, or an operand that finds no operator to combine with
         err_in = err_ff | (val_push_req & vfull) | (cmd.push_op & ofull)
                | (val_pop & vempty) | (cmd.push_operand & prev_ff);
         if (cmd.push_op) begin
            prev_in = 1'b0;
         end else if (cmd.push_operand | cmd.start_combine) begin
            prev_in = 1'b1;
         end
      end

      if (cmd.start_combine) begin
         a_in = operand;
      end else if (cmd.pop_pair) begin
         a_in = popped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         ocount_ff    <= '0;
         prev_ff      <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         ocount_ff    <= ocount_in;
         prev_ff      <= prev_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      a_ff         <= a_in;
      vzero_ff     <= vzero_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   // stack memories, registered read
   always_ff @(posedge clock) begin
      if (vwr_en) begin
         vmem[vcount_ff[ADDR_W-1:0]] <= push_data;
      end
      if (vrd_en) begin
         vrd_ff <= vmem[vtop[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (owr_en) begin
         omem[ocount_ff[ADDR_W-1:0]] <= (sym_ff == SYM_MUL);
      end
      if (op_pop) begin
         ord_ff <= omem[otop[ADDR_W-1:0]];
      end
   end

   always_comb begin
      status.is_operator  = (sym_ff == SYM_ADD) || (sym_ff == SYM_MUL);
      status.is_last      = last_ff;
      status.prev_operand = prev_ff;
      status.ops_empty    = (ocount_ff == '0);
      status.rsp_hold     = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/pee_ctrl.sv
// ----------------------------------------------------------------------------
// pee_ctrl
// Sequencer for item decode, combine steps, drain and result hand-off.
// ----------------------------------------------------------------------------
module pee_ctrl import pee_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      combine_now;

   assign combine_now = ~status.is_operator & status.prev_operand & ~status.ops_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (combine_now) begin
               state_in = S_CALC;
            end else begin
               state_in = status.is_last ? S_DRAIN : S_IDLE;
            end
         end
         S_CALC: begin
            state_in = status.is_last ? S_DRAIN : S_IDLE;
         end
         S_DRAIN: begin
            state_in = status.ops_empty ? S_FINAL : S_POP_OP;
         end
         S_POP_OP: begin
            state_in = S_CALC;
         end
         S_FINAL: begin
            if (!status.rsp_hold) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // nothing is taken while reset is held
            req_ready = ~reset;
            cmd.load  = req_valid;
         end
         S_EXEC: begin
            cmd.push_op       = status.is_operator;
            cmd.start_combine = combine_now;
            cmd.push_operand  = ~status.is_operator & ~combine_now;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
         end
         S_DRAIN: begin
            // pops the right value of a drain step, or the final result
            cmd.pop_a = 1'b1;
         end
         S_POP_OP: begin
            cmd.pop_pair = 1'b1;
         end
         S_FINAL: begin
            cmd.finish = ~status.rsp_hold;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/prefix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_core
// Evaluates prefix expressions of '+', '*' and single-character operands.
//
//   channel  dir  payload                 transaction
//   req      in   symbol[7:0], last       valid & ready
//   rsp      out  value[31:0] s, error    valid & ready
//
// an operator or a plain operand passes S_IDLE and S_EXEC, a combining one also
// S_CALC; a last item adds S_DRAIN, S_POP_OP, S_CALC per pending operator, then
// S_DRAIN and S_FINAL, set by the single registered read port of each stack
// synchronous reset clears counts and flags only, stack contents are not cleared
// the next item is taken while a result waits in the output register; only
// the final step of a later expression stalls on it
// ----------------------------------------------------------------------------
module prefix_expression_evaluator_core import pee_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   pee_req_if.sink   req,
   pee_rsp_if.source rsp
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [VALUE_W-1:0] rsp_value;

   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pee_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_symbol (req.symbol),
      .req_last   (req.last),
      .rsp_value  (rsp_value),
      .rsp_error  (rsp.error),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready)
   );

   assign rsp.value = $signed(rsp_value);

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   a_pop_then_calc: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_combine || cmd.pop_pair) |=> cmd.calc)
      else $error("operator pop not followed by combine");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.rsp_hold)
      else $error("result written over a pending response");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("new transaction taken while an item is in progress");
`endif

endmodule
